FILE: rtl/task_timing_stats_table_core_macros.svh
// Assertion macros for the task timing statistics table.
// Used by the port checker; depends on a clk and arst_n in scope.
`ifndef TASK_TIMING_STATS_TABLE_CORE_MACROS_SVH
`define TASK_TIMING_STATS_TABLE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tts_pkg.sv
// Shared types and constants for the task timing statistics table.
// No dependencies.
package tts_pkg;

	localparam int NUM_REGS  = 6;
	localparam int PADDR_W   = 5;
	localparam int DIV_STEPS = 64;

	localparam logic [1:0] FUNC_PERIODIC = 2'd0;
	localparam logic [1:0] FUNC_CYCLE    = 2'd1;
	localparam logic [1:0] FUNC_SNAPSHOT = 2'd2;

	localparam logic [31:0] US_PER_MS = 32'd1000;

	// One table entry as held in the statistics memory.
	typedef struct packed {
		logic [31:0] sample_count;
		logic [31:0] miss_count;
		logic [63:0] exec_total;
		logic [63:0] abs_jitter_total;
		logic [31:0] last_exec;
		logic [31:0] max_exec;
		logic [31:0] last_jitter;
		logic [31:0] max_abs_jitter;
		logic [31:0] override_period;
		logic        override_flag;
	} entry_t;

endpackage

FILE: rtl/tts_ifs.sv
// Request and response channel interfaces of the timing statistics table.
// Depends on nothing but the clock domain of the user.
interface tts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  task_index;
	logic [31:0] expected_tick;
	logic [31:0] actual_tick;
	logic [31:0] period_ticks;
	logic [31:0] exec_us;
	logic [31:0] cycle_period_ms;

	modport source (output valid, func, task_index, expected_tick, actual_tick,
		period_ticks, exec_us, cycle_period_ms, input ready);
	modport sink (input valid, func, task_index, expected_tick, actual_tick,
		period_ticks, exec_us, cycle_period_ms, output ready);
endinterface

interface tts_rsp_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic [31:0]        period_ms;
	logic [31:0]        sample_count;
	logic [31:0]        miss_count;
	logic [31:0]        last_exec_us;
	logic [31:0]        max_exec_us;
	logic [31:0]        avg_exec_us;
	logic signed [31:0] last_jitter_us;
	logic [31:0]        max_abs_jitter_us;
	logic [31:0]        avg_abs_jitter_us;

	modport source (output valid, found, period_ms, sample_count, miss_count,
		last_exec_us, max_exec_us, avg_exec_us, last_jitter_us,
		max_abs_jitter_us, avg_abs_jitter_us, input ready);
	modport sink (input valid, found, period_ms, sample_count, miss_count,
		last_exec_us, max_exec_us, avg_exec_us, last_jitter_us,
		max_abs_jitter_us, avg_abs_jitter_us, output ready);
endinterface

FILE: rtl/task_timing_stats_table_core.sv
// Task timing statistics table, one transaction at a time. A record is written back
// in ST_UPD, after ST_RD, and a new request is taken only back in ST_IDLE.
// A snapshot runs through ST_DIV and the two 64-step averaging dividers (an empty or
// missing entry skips them) to ST_OUT, where its result is registered; a result still
// unclaimed in the response register stalls a new snapshot.
// Asynchronous active-low reset clears control state, periods and entry valid bits.
module task_timing_stats_table_core import tts_pkg::*; #(
	parameter int NUM_TASKS = 6,
	parameter int TICK_MS   = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	tts_req_if.sink            req,
	tts_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int          IDX_W       = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam logic [31:0] US_PER_TICK = 32'(TICK_MS * 1000);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_UPD,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;

	// Configured periods, one register per task slot of the register map.
	logic [31:0] cfg_q [NUM_REGS];
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (psel && penable && pwrite && (32'(reg_idx) < NUM_REGS)) begin
			cfg_q[reg_idx] <= pwdata;
		end
	end

	assign prdata = (32'(reg_idx) < NUM_REGS) ? cfg_q[reg_idx] : '0;

	// The request is captured on acceptance and the table entry is read at
	// the same edge, so the entry is available in the next cycle.
	logic             accept;
	logic [1:0]       func_q;
	logic [IDX_W-1:0] tidx_q;
	logic             found_q;
	logic [31:0]      exp_q, act_q, per_q, exec_q, cyc_q;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.func;
			tidx_q  <= req.task_index[IDX_W-1:0];
			found_q <= req.task_index < 8'(NUM_TASKS);
			exp_q   <= req.expected_tick;
			act_q   <= req.actual_tick;
			per_q   <= req.period_ticks;
			exec_q  <= req.exec_us;
			cyc_q   <= req.cycle_period_ms;
		end
	end

	// First stage: the scaling multiplications, registered before use.
	logic [31:0] dticks;
	logic [31:0] jit_s1, limit_s1, cyc_lim_s1;
	logic        late_s1;

	assign dticks = act_q - exp_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			jit_s1     <= dticks * US_PER_TICK;
			limit_s1   <= per_q * US_PER_TICK;
			cyc_lim_s1 <= cyc_q * US_PER_MS;
			late_s1    <= (dticks != '0) && !dticks[31];
		end
	end

	// Read-modify-write of the entry. Only one transaction is in flight, so
	// the write-back always lands before the next read.
	entry_t ent, upd;
	logic   wr_en;
	logic [31:0] absj;
	logic        miss;

	tts_mem #(.DEPTH(NUM_TASKS), .AW(IDX_W)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (req.task_index[IDX_W-1:0]),
		.wr_en   (wr_en),
		.wr_addr (tidx_q),
		.wr_data (upd),
		.rd_data (ent)
	);

	assign absj = jit_s1[31] ? (32'd0 - jit_s1) : jit_s1;

	always_comb begin
		upd          = ent;
		miss         = 1'b0;
		upd.sample_count = ent.sample_count + 32'd1;
		upd.exec_total   = ent.exec_total + {32'd0, exec_q};
		upd.last_exec    = exec_q;
		if (exec_q > ent.max_exec) begin
			upd.max_exec = exec_q;
		end
		if (func_q == FUNC_PERIODIC) begin
			miss                 = late_s1 || (exec_q > limit_s1);
			upd.abs_jitter_total = ent.abs_jitter_total + {32'd0, absj};
			upd.last_jitter      = jit_s1;
			if (absj > ent.max_abs_jitter) begin
				upd.max_abs_jitter = absj;
			end
		end else begin
			miss                = (cyc_q != '0) && (exec_q > cyc_lim_s1);
			upd.override_period = cyc_q;
			upd.override_flag   = 1'b1;
			upd.last_jitter     = '0;
		end
		if (miss) begin
			upd.miss_count = ent.miss_count + 32'd1;
		end
	end

	assign wr_en = (state_q == ST_UPD) && found_q &&
		((func_q == FUNC_PERIODIC) || (func_q == FUNC_CYCLE));

	// Snapshot averages: both divisions run side by side.
	logic        div_start;
	logic        div_done_e, div_done_j;
	logic [31:0] avg_exec, avg_jit;
	logic        snap_go;

	assign snap_go   = (func_q == FUNC_SNAPSHOT) && found_q;
	assign div_start = (state_q == ST_UPD) && snap_go && (ent.sample_count != '0);

	tts_div u_div_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ent.exec_total),
		.divisor  (ent.sample_count),
		.done     (div_done_e),
		.quotient (avg_exec)
	);

	tts_div u_div_jit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ent.abs_jitter_total),
		.divisor  (ent.sample_count),
		.done     (div_done_j),
		.quotient (avg_jit)
	);

	// Response register; it holds until the sink takes it.
	logic        out_vld_q;
	logic        free;
	logic        zero_n;
	logic [31:0] period_sel;

	assign free       = !out_vld_q || rsp.ready;
	assign zero_n     = (ent.sample_count == '0);
	assign period_sel = ent.override_flag ? ent.override_period : cfg_q[tidx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			// A new result replaces one that is taken at the same edge.
			if (state_q == ST_OUT && free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (func_q != FUNC_SNAPSHOT) begin
						state_q <= ST_IDLE;
					end else if (div_start) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_done_e && div_done_j) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && free) begin
			if (snap_go) begin
				rsp.found             <= 1'b1;
				rsp.period_ms         <= period_sel;
				rsp.sample_count      <= ent.sample_count;
				rsp.miss_count        <= ent.miss_count;
				rsp.last_exec_us      <= ent.last_exec;
				rsp.max_exec_us       <= ent.max_exec;
				rsp.avg_exec_us       <= zero_n ? '0 : avg_exec;
				rsp.last_jitter_us    <= ent.last_jitter;
				rsp.max_abs_jitter_us <= ent.max_abs_jitter;
				rsp.avg_abs_jitter_us <= zero_n ? '0 : avg_jit;
			end else begin
				rsp.found             <= 1'b0;
				rsp.period_ms         <= '0;
				rsp.sample_count      <= '0;
				rsp.miss_count        <= '0;
				rsp.last_exec_us      <= '0;
				rsp.max_exec_us       <= '0;
				rsp.avg_exec_us       <= '0;
				rsp.last_jitter_us    <= '0;
				rsp.max_abs_jitter_us <= '0;
				rsp.avg_abs_jitter_us <= '0;
			end
		end
	end

	assign rsp.valid = out_vld_q;

endmodule

FILE: rtl/tts_mem.sv
// Statistics memory: one entry per task, registered read, per-entry valid bits.
// Depends on tts_pkg for the entry type.
module tts_mem import tts_pkg::*; #(
	parameter int DEPTH = 6,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	output entry_t        rd_data
);

	entry_t             mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	entry_t             rd_q;
	logic               rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en && (32'(wr_addr) < DEPTH)) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en && (32'(rd_addr) < DEPTH)) begin
			rd_q <= mem[rd_addr];
		end
	end

	// An entry never written reads as zero, which is its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en && (32'(wr_addr) < DEPTH)) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= (32'(rd_addr) < DEPTH) && vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

FILE: rtl/tts_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on tts_pkg for the step count.
module tts_div import tts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 7'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q[31:0];

endmodule

FILE: rtl/tts_chk.sv
// Port-level checker for the task timing statistics table, bound to the top.
// Depends on the assertion macro header.
`include "task_timing_stats_table_core_macros.svh"

module tts_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        found,
	input logic [31:0] period_ms,
	input logic [31:0] sample_count,
	input logic [31:0] miss_count,
	input logic [31:0] avg_exec_us,
	input logic [31:0] avg_abs_jitter_us
);

	`TTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
	`TTS_ASSERT_NEXT(a_one_at_time, req_valid && req_ready, !req_ready, "request accepted while busy")
	`TTS_ASSERT_SAME(a_miss_found, rsp_valid && !found, period_ms == 32'd0 && sample_count == 32'd0 && miss_count == 32'd0, "missing task gave nonzero fields")
	`TTS_ASSERT_SAME(a_avg_empty, rsp_valid && sample_count == 32'd0, avg_exec_us == 32'd0 && avg_abs_jitter_us == 32'd0, "average without samples")

endmodule

bind task_timing_stats_table_core tts_chk u_tts_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.found             (rsp.found),
	.period_ms         (rsp.period_ms),
	.sample_count      (rsp.sample_count),
	.miss_count        (rsp.miss_count),
	.avg_exec_us       (rsp.avg_exec_us),
	.avg_abs_jitter_us (rsp.avg_abs_jitter_us)
);
